FILE: rtl/cfzp_pkg.sv
// Shared types and constants for the centered zero-padded FIR core.
// No dependencies; imported by every module of the block.
package cfzp_pkg;

  localparam int MAX_HALF_DEF = 3;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int NUM_COEF     = 7;
  localparam int HW_W         = 2;
  localparam int FRAC_BITS    = 15;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 16;

  // register map
  localparam logic [CFG_ADDR_W-1:0] REG_HALF_WIDTH = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_BASE  = 3'd1;

  localparam logic signed [COEF_W-1:0] COEF0_RESET = 16'sh7FFF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       final_res;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

FILE: rtl/cfzp_cell.sv
// One tap cell: delay-line stage, registered product and partial-sum stage.
// Depends on cfzp_pkg.
module cfzp_cell import cfzp_pkg::*; #(
  parameter int ACC_W = SAMPLE_W + COEF_W + 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cell_ctrl_t                 ctrl,
  input  logic signed [SAMPLE_W-1:0] x_in,
  output logic signed [SAMPLE_W-1:0] x_out,
  input  logic signed [COEF_W-1:0]   coef,
  input  logic                       tap_en,
  input  logic signed [ACC_W-1:0]    sum_in,
  output logic signed [ACC_W-1:0]    sum_out
);

  localparam int PROD_W = SAMPLE_W + COEF_W;

  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
    end else if (ctrl.clear) begin
      x_r <= '0;
    end else if (ctrl.shift) begin
      x_r <= x_in;
    end
  end

  // product and sum stages settle while the line holds still
  always_ff @(posedge clk) begin
    prod_r <= tap_en ? PROD_W'(x_r * coef) : '0;
    sum_r  <= sum_in + ACC_W'(prod_r);
  end

  assign x_out   = x_r;
  assign sum_out = sum_r;

endmodule

FILE: rtl/cfzp_out.sv
// Result stage: rounding, shift, saturation and the output holding register.
// Depends on cfzp_pkg.
module cfzp_out import cfzp_pkg::*; #(
  parameter int ACC_W = SAMPLE_W + COEF_W + 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  logic signed [ACC_W-1:0] acc,
  input  logic                    final_in,
  output logic                    slot_free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data
);

  localparam logic signed [ACC_W:0] RND_C  = (ACC_W+1)'(2 ** (FRAC_BITS - 1));
  localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W+2-SAMPLE_W){1'b0}},
                                              {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

  logic signed [ACC_W:0]      rnd;
  logic signed [ACC_W:0]      shf;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       valid_r;
  out_item_t                  data_r;

  always_comb begin
    rnd = {acc[ACC_W-1], acc} + RND_C;
    shf = rnd >>> FRAC_BITS;
    if (shf > SAT_HI) begin
      sat = SAT_HI[SAMPLE_W-1:0];
    end else if (shf < SAT_LO) begin
      sat = SAT_LO[SAMPLE_W-1:0];
    end else begin
      sat = shf[SAMPLE_W-1:0];
    end
  end

  assign slot_free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r.filtered  <= sat;
      data_r.final_res <= final_in;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: rtl/centered_fir_zero_padded_core.sv
// Top level of the centered odd-length FIR core with zero padding.
// Depends on cfzp_pkg, cfzp_cell and cfzp_out.
//
// Centered FIR over 2M+1 taps (M = half_width, clamped to MAX_HALF), built as
// a row of 2*MAX_HALF+1 tap cells. Each cell holds one delay-line sample, a
// registered product and one stage of the partial-sum chain. Every sample
// transaction shifts the line once; the block emits y[n-M] once M samples of
// look-ahead have arrived. A sample flagged end_of_stream shifts M zeros
// after it, emitting the pending outputs with final_res on the last one,
// then clears the line, so each stream yields as many outputs as inputs.
// A shift that produces an output goes from acceptance to ready through the
// shift, the product register, the sum rippling through all 2*MAX_HALF+1
// cells and the emit step. A warm-up sample with no output and no end flag
// leaves the core idle. The final sample makes such a pass for itself and
// for each of its M padding zeros. A result waiting in the output register
// does not block input; only a second result waits for the first to go.
// Arithmetic: exact sum of Q1.15 products, add 2^14, arithmetic shift by 15,
// saturate to 16 bits. Configuration writes are taken at any time but are
// meant to happen only while idle.
module centered_fir_zero_padded_core import cfzp_pkg::*; #(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TAPS  = 2 * MAX_HALF + 1;
  localparam int ACC_W = SAMPLE_W + COEF_W + $clog2(TAPS);
  localparam int M_W   = $clog2(MAX_HALF + 1);
  localparam int CNT_W = $clog2(TAPS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // ---------------- configuration registers ----------------
  logic [HW_W-1:0]          half_width_r;
  logic signed [COEF_W-1:0] coef_r [NUM_COEF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= '0;
      for (int j = 0; j < NUM_COEF; j++) begin
        coef_r[j] <= (j == 0) ? COEF0_RESET : '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_HALF_WIDTH) begin
        half_width_r <= cfg_wdata[HW_W-1:0];
      end
      for (int j = 0; j < NUM_COEF; j++) begin
        if (cfg_index == REG_COEF_BASE + CFG_ADDR_W'(j)) begin
          coef_r[j] <= cfg_wdata[COEF_W-1:0];
        end
      end
    end
  end

  // effective half width, clamped
  logic [M_W-1:0] m;
  assign m = (int'(half_width_r) > MAX_HALF) ? M_W'(MAX_HALF) : M_W'(half_width_r);

  // ---------------- control ----------------
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [M_W-1:0]   seen_r, seen_nxt;
  logic [M_W-1:0]   flush_r, flush_nxt;
  logic             due_r, due_nxt;
  logic             last_r, last_nxt;

  cell_ctrl_t                 cell_ctrl;
  logic signed [SAMPLE_W-1:0] shift_val;
  logic                       in_acc;
  logic                       out_free;
  logic                       emit_load;
  logic                       emit_final;
  logic [M_W-1:0]             seen_inc;
  logic                       due_now;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign seen_inc = (int'(seen_r) == MAX_HALF) ? seen_r : seen_r + M_W'(1);
  assign due_now  = (seen_r >= m);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    seen_nxt   = seen_r;
    flush_nxt  = flush_r;
    due_nxt    = due_r;
    last_nxt   = last_r;
    cell_ctrl  = '0;
    shift_val  = '0;
    emit_load  = 1'b0;
    emit_final = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cell_ctrl.shift = 1'b1;
          shift_val       = in_data.sample;
          seen_nxt        = seen_inc;
          due_nxt         = due_now;
          last_nxt        = in_data.end_of_stream;
          flush_nxt       = in_data.end_of_stream ? m : '0;
          cnt_nxt         = '0;
          // warm-up sample: nothing to compute
          if (due_now || in_data.end_of_stream) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        if (cnt_r == CNT_W'(TAPS)) begin
          state_nxt = ST_EMIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (!due_r || out_free) begin
          emit_load  = due_r;
          emit_final = last_r && (flush_r == '0);
          if (flush_r != '0) begin
            // next zero-padding shift
            cell_ctrl.shift = 1'b1;
            seen_nxt        = seen_inc;
            due_nxt         = due_now;
            flush_nxt       = flush_r - M_W'(1);
            cnt_nxt         = '0;
            state_nxt       = ST_CALC;
          end else begin
            if (last_r) begin
              cell_ctrl.clear = 1'b1;
              seen_nxt        = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      seen_r  <= '0;
      flush_r <= '0;
      due_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
      flush_r <= flush_nxt;
      due_r   <= due_nxt;
      last_r  <= last_nxt;
    end
  end

  // ---------------- cell row ----------------
  logic signed [SAMPLE_W-1:0] x_w   [TAPS+1];
  logic signed [ACC_W-1:0]    sum_w [TAPS+1];
  logic                       tap_en [TAPS];

  assign x_w[0]   = shift_val;
  assign sum_w[0] = '0;

  for (genvar j = 0; j < TAPS; j++) begin : g_cell
    logic signed [COEF_W-1:0] cell_coef;
    if (j < NUM_COEF) begin : g_coef
      assign cell_coef = coef_r[j];
      assign tap_en[j] = (j <= 2 * int'(m));
    end else begin : g_nocoef
      assign cell_coef = '0;
      assign tap_en[j] = 1'b0;
    end

    cfzp_cell #(
      .ACC_W (ACC_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl),
      .x_in    (x_w[j]),
      .x_out   (x_w[j+1]),
      .coef    (cell_coef),
      .tap_en  (tap_en[j]),
      .sum_in  (sum_w[j]),
      .sum_out (sum_w[j+1])
    );
  end

  // ---------------- output stage ----------------
  cfzp_out #(
    .ACC_W (ACC_W)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (emit_load),
    .acc       (sum_w[TAPS]),
    .final_in  (emit_final),
    .slot_free (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // ---------------- assertions ----------------
  // a result is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load |-> out_free)
    else $error("result loaded over a pending transaction");

  // shift count saturates at the maximum half width
  a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    int'(seen_r) <= MAX_HALF)
    else $error("seen count past its limit");

  // the delay line holds still while the sum chain settles
  a_calc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (!cell_ctrl.shift && !cell_ctrl.clear
                              && int'(cnt_r) <= TAPS))
    else $error("delay line moved during accumulation");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for centered_fir_zero_padded_core.
// Depends on cfzp_pkg and the core RTL only. It predicts every filtered output
// and checks each output transaction against that prediction.
module tb import cfzp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS = 2 * MAX_HALF_DEF + 1;
  // The slowest transaction is a final sample at the widest filter; SETTLE
  // waits it out with margin.
  localparam int SETTLE = (MAX_HALF_DEF + 1) * (2 * MAX_HALF_DEF + 3) + 12;
  localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_W - 1));
  localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  centered_fir_zero_padded_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Filter shadow: register copies, delay line and warm-up count. Line and
  // count are updated at the clock edge where a sample transaction is accepted.
  // ---------------------------------------------------------------------------
  logic [HW_W-1:0]            hw_shadow;
  logic signed [COEF_W-1:0]   coef_shadow [NUM_COEF];
  logic signed [SAMPLE_W-1:0] tap_line [TAPS];
  int unsigned                warm_count;

  // Outputs predicted but not yet seen on the output port, oldest first.
  out_item_t pending_outputs[$];
  int        error_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  // Shift one value into the delay line; returns 1 with the filtered value
  // when enough look-ahead is present to produce y[n-M].
  function automatic bit shift_and_filter(input logic signed [SAMPLE_W-1:0] v,
                                          output logic signed [SAMPLE_W-1:0] y);
    int     m;
    bit     due;
    longint acc;
    m   = (hw_shadow > MAX_HALF_DEF) ? MAX_HALF_DEF : int'(hw_shadow);
    due = (warm_count >= m);
    y   = '0;
    for (int i = TAPS - 1; i > 0; i--) tap_line[i] = tap_line[i-1];
    tap_line[0] = v;
    if (warm_count < MAX_HALF_DEF) warm_count++;
    if (!due) return 1'b0;
    acc = 0;
    for (int j = 0; j <= 2 * m; j++)
      acc += longint'(tap_line[j]) * longint'(coef_shadow[j]);
    // round half up, then floor by an arithmetic shift
    acc = (acc + ROUND_HALF) >>> FRAC_BITS;
    if (acc > SAT_HI) acc = SAT_HI;
    else if (acc < SAT_LO) acc = SAT_LO;
    y = acc[SAMPLE_W-1:0];
    return 1'b1;
  endfunction

  // Work out every output caused by one accepted sample and queue it.
  function automatic void predict_outputs(input in_item_t it);
    out_item_t                  produced[$];
    out_item_t                  r;
    logic signed [SAMPLE_W-1:0] y;
    int                         m;
    m = (hw_shadow > MAX_HALF_DEF) ? MAX_HALF_DEF : int'(hw_shadow);
    r.final_res = 1'b0;
    if (shift_and_filter(it.sample, y)) begin
      r.filtered = y;
      produced.push_back(r);
    end
    if (it.end_of_stream) begin
      // flush: M zeros past the end of the stream
      for (int f = 0; f < m; f++) begin
        if (shift_and_filter('0, y)) begin
          r.filtered = y;
          produced.push_back(r);
        end
      end
      if (produced.size() > 0) produced[produced.size()-1].final_res = 1'b1;
      foreach (tap_line[i]) tap_line[i] = '0;
      warm_count = 0;
    end
    foreach (produced[i]) pending_outputs.push_back(produced[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random backpressure plus the checker. out_ready and the
  // outputs are read before this edge's updates, so the handshake is the one
  // the core saw.
  // ---------------------------------------------------------------------------
  out_item_t head_item;

  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        error_count++;
        $display("%0t unexpected output transaction: expected none,",
                 $time, " got filtered=%0d final_res=%0b",
                 out_data.filtered, out_data.final_res);
      end else begin
        head_item = pending_outputs.pop_front();
        if (out_data.filtered !== head_item.filtered) begin
          error_count++;
          $display("%0t filtered mismatch: expected %0d, got %0d",
                   $time, head_item.filtered, out_data.filtered);
        end
        if (out_data.final_res !== head_item.final_res) begin
          error_count++;
          $display("%0t final_res mismatch: expected %0b, got %0b",
                   $time, head_item.final_res, out_data.final_res);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side helpers. Everything is entered and left on a rising edge.
  // ---------------------------------------------------------------------------

  // Send one sample transaction; random idle cycles go in front of it.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic eos);
    in_item_t it;
    it.sample        = s;
    it.end_of_stream = eos;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    predict_outputs(it);
  endtask

  // Stop sending and wait until every predicted output has come out. With
  // settle set, also wait out a worst-case transaction that yields no output,
  // so the core is idle before a register write.
  task automatic drain_outputs(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_outputs.size() != 0);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  // Write half_width and all seven taps, back to back. hw_junk lands in the
  // unused upper bits of the half_width write.
  task automatic program_filter(input logic [HW_W-1:0] hw,
                                input logic [NUM_COEF-1:0][COEF_W-1:0] taps,
                                input logic [CFG_DATA_W-HW_W-1:0] hw_junk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_WIDTH;
    cfg_wdata <= {hw_junk, hw};
    @(posedge clk);
    hw_shadow = hw;
    for (int k = 0; k < NUM_COEF; k++) begin
      cfg_index <= REG_COEF_BASE + CFG_ADDR_W'(k);
      cfg_wdata <= taps[k];
      @(posedge clk);
      coef_shadow[k] = taps[k];
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return 16'(int'($urandom_range(2047)) - 1024);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return '0;
      3, 4:    return 16'(int'($urandom_range(8191)) - 4096);
      default: return 16'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: half_width 0 and tap 0 just under +1.0, so each sample comes
  // back almost unchanged, one output per input. Extremes of the sample range.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd0, 1'b1);
  endtask

  // Half-LSB products: rounding goes toward +inf on the exact half.
  task automatic test_rounding();
    drain_outputs(1'b1);
    program_filter(2'd0, {{6{16'h0000}}, 16'h4000}, '0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd3, 1'b1);
  endtask

  // Full-scale taps and samples drive the sum past both rails.
  task automatic test_saturation();
    drain_outputs(1'b1);
    program_filter(2'd1, {{4{16'h7FFF}}, {3{16'h8000}}}, '1);
    repeat (2) send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    repeat (2) send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
  endtask

  // Streams shorter than M: nothing until end_of_stream, then the whole
  // stream comes out of the zero-padded flush.
  task automatic test_short_streams();
    logic [NUM_COEF-1:0][COEF_W-1:0] t;
    for (int k = 0; k < NUM_COEF; k++) t[k] = rand_coef();
    drain_outputs(1'b1);
    program_filter(2'd3, t, '0);
    send_sample(rand_sample(), 1'b1);
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b1);
  endtask

  // half_width narrowed in the middle of a stream; the sender also holds off
  // until all outputs so far are out.
  task automatic test_midstream_width();
    drain_outputs(1'b1);
    program_filter(2'd3, {16'h7FFF, 16'h8000, 16'h2000, 16'h7FFF,
                          16'hE000, 16'h8000, 16'h1000}, '0);
    repeat (4) send_sample(rand_sample(), 1'b0);
    drain_outputs(1'b1);
    cfg_we    <= 1'b1;
    cfg_index <= REG_HALF_WIDTH;
    cfg_wdata <= CFG_DATA_W'(1);
    @(posedge clk);
    hw_shadow = 2'd1;
    cfg_we <= 1'b0;
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b0);
    send_sample(rand_sample(), 1'b1);
  endtask

  // Random streams under a random filter that changes every few streams.
  // Most streams are short; some are long enough to fill the whole line,
  // and short ones exercise the flush-only path.
  task automatic test_random_streams(input int n_items, input int s_pct, input int r_pct);
    logic [NUM_COEF-1:0][COEF_W-1:0] t;
    int sent;
    int streams_left;
    int len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent          = 0;
    streams_left  = 0;
    while (sent < n_items) begin
      if (streams_left == 0) begin
        drain_outputs(1'b1);
        for (int k = 0; k < NUM_COEF; k++) t[k] = rand_coef();
        program_filter(2'($urandom_range(3)), t, 14'($urandom()));
        streams_left = $urandom_range(1, 4);
      end
      // now and then hold off until the output side has caught up
      if ($urandom_range(29) == 0) drain_outputs(1'b0);
      len = ($urandom_range(7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
      sent += len;
      streams_left--;
    end
    drain_outputs(1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // shadow starts at the core's reset values
    hw_shadow = '0;
    foreach (coef_shadow[k]) coef_shadow[k] = '0;
    coef_shadow[0] = COEF0_RESET;
    foreach (tap_line[i]) tap_line[i] = '0;
    warm_count = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 59;
    test_reset_defaults();
    test_rounding();
    test_saturation();
    test_short_streams();
    test_midstream_width();

    test_random_streams(155, 23, 59);
    test_random_streams(155, 59, 23);
    test_random_streams(155, 0, 0);

    if (error_count == 0 && pending_outputs.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Watchdog: 4 ms, far above the slowest legal run.
  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
